>>> sv/masc_pkg.sv
// Shared constants and types for the masked adjacent-swap sort checker.
package masc_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MASK_BITS       = 63;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic load;
        logic sort;
        logic check;
        logic phase;
    } seq_ctrl_t;

endpackage

>>> sv/masc_cell.sv
// One element cell of the odd-even compare-and-swap chain.
module masc_cell #(
    parameter int VALUE_WIDTH = masc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          load_en,
    input  logic signed [VALUE_WIDTH-1:0] load_value,
    input  logic signed [VALUE_WIDTH-1:0] left_value,
    input  logic signed [VALUE_WIDTH-1:0] right_value,
    input  logic                          swap_left,
    input  logic                          swap_right_en,
    output logic signed [VALUE_WIDTH-1:0] value,
    output logic                          swap_right,
    output logic                          desc
);
    import masc_pkg::*;

    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH-1:0] value_next;
    logic                          gt;

    assign gt         = value_reg > right_value;
    assign swap_right = swap_right_en & gt;
    assign desc       = gt;
    assign value      = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (load_en)
        begin
            value_next = load_value;
        end
        else if (swap_right)
        begin
            value_next = right_value;
        end
        else if (swap_left)
        begin
            value_next = left_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> sv/masc_ctrl.sv
// Sequencer: element count, overflow flag and sort round counter.
module masc_ctrl #(
    parameter int MAX_LEN = masc_pkg::MAX_LEN_DEF,
    parameter int CW      = $clog2(MAX_LEN + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                last,
    output logic                busy,
    output logic [CW-1:0]       count,
    output logic                ovf,
    output masc_pkg::seq_ctrl_t ctrl
);
    import masc_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] round_reg;
    logic [CW-1:0] round_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          accept;
    logic          room;
    logic          rounds_done;

    assign accept      = start & (state_reg == ST_LOAD);
    assign room        = count_reg < CW'(MAX_LEN);
    assign rounds_done = round_reg == count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && last)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (rounds_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        ctrl       = '0;
        busy       = 1'b1;
        count_next = count_reg;
        round_next = round_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                busy       = 1'b0;
                round_next = '0;
                if (accept)
                begin
                    if (room)
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_SORT:
            begin
                ctrl.phase = round_reg[0];
                if (!rounds_done)
                begin
                    ctrl.sort  = 1'b1;
                    round_next = round_reg + CW'(1);
                end
            end
            ST_CHECK:
            begin
                ctrl.check = 1'b1;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            round_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign count = count_reg;
    assign ovf   = ovf_reg;

endmodule

>>> sv/masked_adjacent_swap_sort_check.sv
// Top level of the masked adjacent-swap sort checker.
//
// Usage: an element transaction is taken at a rising edge with start high and
// busy low; value is the element, last closes the array. Elements beyond
// MAX_LEN are dropped and flagged. The user writes the swap mask through
// cfg_valid/cfg_ready/cfg_swap_mask (cfg_ready is always high) only while
// idle, unenforced by the block; bit j lets elements j and j+1 swap.
// Each element is registered into its cell at the edge that accepts it.
// After the closing element busy stays high through n odd-even rounds
// across the cell chain (n = elements held), one idle round-end step and
// one check step. The result (sortable, overflow) then shows for exactly
// one cycle with done high, and a new array may start in that same cycle.
// Sorting time is set by the round counter, one compare-and-swap round per
// cycle. The receiver cannot stall; done is a single-cycle strobe.
// Reset (rst_n low, asynchronous) clears the mask, the element count, the
// overflow flag and the sequencer; cell contents are undefined until loaded.
module masked_adjacent_swap_sort_check #(
    parameter int MAX_LEN     = masc_pkg::MAX_LEN_DEF,
    parameter int VALUE_WIDTH = masc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [VALUE_WIDTH-1:0]        value,
    input  logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [masc_pkg::MASK_BITS-1:0] cfg_swap_mask,
    output logic                                 done,
    output logic                                 sortable,
    output logic                                 overflow
);
    import masc_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [MASK_BITS-1:0]          swap_mask_reg;
    logic                          done_reg;
    logic                          sortable_reg;
    logic                          overflow_reg;
    logic [CW-1:0]                 count;
    logic                          ovf;
    seq_ctrl_t                     ctrl;

    logic signed [VALUE_WIDTH-1:0] cell_value [MAX_LEN];
    logic [MAX_LEN-1:0]            cell_swap;
    logic [MAX_LEN-1:0]            cell_desc;
    logic [MAX_LEN-1:0]            swap_en;
    logic [MAX_LEN-1:0]            bad;

    assign cfg_ready = 1'b1;

    masc_ctrl #(
        .MAX_LEN (MAX_LEN),
        .CW      (CW)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .busy  (busy),
        .count (count),
        .ovf   (ovf),
        .ctrl  (ctrl)
    );

    genvar i;
    generate
        for (i = 0; i < MAX_LEN; i++)
        begin : g_cell
            logic                          load_en;
            logic signed [VALUE_WIDTH-1:0] left_v;
            logic signed [VALUE_WIDTH-1:0] right_v;
            logic                          swap_l;

            assign load_en = ctrl.load & (count == CW'(i));

            if (i == 0)
            begin : g_first
                assign left_v = '0;
                assign swap_l = 1'b0;
            end
            else
            begin : g_mid
                assign left_v = cell_value[i-1];
                assign swap_l = cell_swap[i-1];
            end

            if (i == MAX_LEN - 1)
            begin : g_end
                assign right_v    = '0;
                assign swap_en[i] = 1'b0;
                assign bad[i]     = 1'b0;
            end
            else
            begin : g_pair
                logic in_range;
                logic mask_ok;

                assign right_v  = cell_value[i+1];
                assign in_range = count > CW'(i + 1);
                if (i < MASK_BITS)
                begin : g_mask
                    assign mask_ok = swap_mask_reg[i];
                end
                else
                begin : g_nomask
                    assign mask_ok = 1'b0;
                end
                assign swap_en[i] = ctrl.sort & (ctrl.phase == 1'(i % 2))
                                    & mask_ok & in_range;
                assign bad[i]     = cell_desc[i] & in_range;
            end

            masc_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk           (clk),
                .load_en       (load_en),
                .load_value    (value),
                .left_value    (left_v),
                .right_value   (right_v),
                .swap_left     (swap_l),
                .swap_right_en (swap_en[i]),
                .value         (cell_value[i]),
                .swap_right    (cell_swap[i]),
                .desc          (cell_desc[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_mask_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                swap_mask_reg <= cfg_swap_mask;
            end
            done_reg <= ctrl.check;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.check)
        begin
            sortable_reg <= ~|bad;
            overflow_reg <= ovf;
        end
    end

    assign done     = done_reg;
    assign sortable = sortable_reg;
    assign overflow = overflow_reg;

endmodule

>>> sv/masc_check.sv
// Port-level checks for the masked adjacent-swap sort checker, bound to the top.
module masc_check (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last,
    input logic done,
    input logic sortable,
    input logic overflow
);
    import masc_pkg::*;

    // closing transaction starts the sort
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last |=> busy)
        else $error("busy not raised after closing transaction");

    // result only appears once the sequencer is back to loading
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({sortable, overflow}))
        else $error("result fields unknown during strobe");

endmodule

bind masked_adjacent_swap_sort_check masc_check u_masc_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .last     (last),
    .done     (done),
    .sortable (sortable),
    .overflow (overflow)
);

>>> bench/testbench.sv
// Self-checking testbench for the masked adjacent-swap sort checker.
module testbench;
    import masc_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEF;
    localparam int VW      = VALUE_WIDTH_DEF;
    localparam logic [MASK_BITS-1:0] MASK_ALL  = '1;
    localparam logic [MASK_BITS-1:0] MASK_NONE = '0;
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 138;

    typedef struct {
        logic signed [VW-1:0] value;
        logic                 last;
    } element_t;

    typedef struct {
        logic sortable;
        logic overflow;
    } verdict_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [VW-1:0] value = '0;
    logic                 last = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [MASK_BITS-1:0] cfg_swap_mask = '0;
    logic                 done;
    logic                 sortable;
    logic                 overflow;

    element_t element_queue[$];
    verdict_t expected_verdicts[$];

    // predictor state
    logic signed [VW-1:0] held [MAX_LEN];
    int                   held_count = 0;
    bit                   dropped = 1'b0;
    logic [MASK_BITS-1:0] mask_model = '0;

    int idle_pct = 0;
    int error_count = 0;
    int items_queued = 0;
    int arrays_checked = 0;
    int sortable_count = 0;
    int overflow_count = 0;
    int masks_written = 0;

    masked_adjacent_swap_sort_check uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_swap_mask(cfg_swap_mask),
        .done         (done),
        .sortable     (sortable),
        .overflow     (overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic bit ascending_after_swaps(input logic signed [VW-1:0] cells [MAX_LEN],
                                                 input int n,
                                                 input logic [MASK_BITS-1:0] mask);
        logic signed [VW-1:0] t;
        int pass;
        int j;
        for (pass = 0; pass < n; pass++)
            for (j = 0; j + 1 < n; j++)
                if (cells[j] > cells[j+1] && j < MASK_BITS && mask[j])
                begin
                    t          = cells[j];
                    cells[j]   = cells[j+1];
                    cells[j+1] = t;
                end
        for (j = 0; j + 1 < n; j++)
            if (cells[j] > cells[j+1])
                return 1'b0;
        return 1'b1;
    endfunction

    // driver: presents queued elements, holds while busy, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        element_t e;
        if (!rst_n)
        begin
            start <= 1'b0;
            value <= '0;
            last  <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (held_count < MAX_LEN)
                begin
                    held[held_count] = value;
                    held_count++;
                end
                else
                    dropped = 1'b1;
                if (last)
                begin
                    v.sortable = ascending_after_swaps(held, held_count, mask_model);
                    v.overflow = dropped;
                    expected_verdicts.push_back(v);
                    held_count = 0;
                    dropped    = 1'b0;
                end
            end
            if (!(start && busy))
            begin
                if (element_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    e = element_queue.pop_front();
                    start <= 1'b1;
                    value <= e.value;
                    last  <= e.last;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: one verdict per done strobe
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
                note_mismatch("result strobe with no transaction outstanding");
            else
            begin
                want = expected_verdicts.pop_front();
                arrays_checked++;
                if (want.sortable)
                    sortable_count++;
                if (want.overflow)
                    overflow_count++;
                if (sortable !== want.sortable)
                    note_mismatch($sformatf("sortable %b, expected %b",
                                            sortable, want.sortable));
                if (overflow !== want.overflow)
                    note_mismatch($sformatf("overflow %b, expected %b",
                                            overflow, want.overflow));
            end
        end
    end

    task automatic push_element(input logic signed [VW-1:0] v, input logic is_last);
        element_t e;
        e.value = v;
        e.last  = is_last;
        element_queue.push_back(e);
        items_queued++;
    endtask

    task automatic write_swap_mask(input logic [MASK_BITS-1:0] m);
        @(posedge clk);
        cfg_valid     <= 1'b1;
        cfg_swap_mask <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        mask_model = m;
        masks_written++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (element_queue.size() != 0 || start || expected_verdicts.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [MASK_BITS-1:0] random_mask();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[MASK_BITS-1:0];
    endfunction

    function automatic logic [MASK_BITS-1:0] phase_mask(input int p);
        case (p % 10)
            0: return MASK_ALL;
            1: return MASK_NONE;
            3: return 63'h2AAA_AAAA_AAAA_AAAA;
            4: return 63'h5555_5555_5555_5555;
            5: return random_mask() & random_mask() & random_mask();
            6: return random_mask() | random_mask();
            7: return MASK_ALL ^ (63'd1 << $urandom_range(MASK_BITS - 1));
            8: return random_mask() & ((63'd1 << $urandom_range(1, MASK_BITS - 1)) - 63'd1);
            default: return random_mask();
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 90)
            return $urandom_range(9, 24);
        else if (r < 97)
            return $urandom_range(25, MAX_LEN);
        return $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
    endfunction

    task automatic queue_array(input int n);
        logic signed [VW-1:0] vals [$];
        logic signed [VW-1:0] t;
        int style;
        int base;
        int i;
        int k;
        style = $urandom_range(6);
        base  = $urandom_range(1000) - 500;
        for (i = 0; i < n; i++)
        begin
            case (style)
                0: vals.push_back($urandom());
                1: vals.push_back($signed($urandom_range(8)) - 4);
                2, 3:
                begin
                    base += $urandom_range(3);
                    vals.push_back(base);
                end
                4:
                begin
                    base -= $urandom_range(3);
                    vals.push_back(base);
                end
                default:
                begin
                    case ($urandom_range(4))
                        0: vals.push_back(VAL_MIN);
                        1: vals.push_back(VAL_MAX);
                        2: vals.push_back('0);
                        3: vals.push_back(-1);
                        default: vals.push_back($urandom());
                    endcase
                end
            endcase
        end
        // nearly sorted: one adjacent pair out of order
        if (style == 3 && n > 1)
        begin
            k         = $urandom_range(n - 2);
            t         = vals[k];
            vals[k]   = vals[k+1];
            vals[k+1] = t;
        end
        for (i = 0; i < n; i++)
            push_element(vals[i], i == n - 1);
    endtask

    initial
    begin
        int p;
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 30;
        write_swap_mask(MASK_ALL);
        push_element(VAL_MIN, 1'b1);
        push_element(VAL_MAX, 1'b1);
        push_element(VAL_MAX, 1'b0);
        push_element(VAL_MIN, 1'b1);
        push_element(0, 1'b0);
        push_element(-1, 1'b0);
        push_element(1, 1'b1);
        wait_drained();

        write_swap_mask(MASK_NONE);
        push_element(VAL_MIN, 1'b0);
        push_element(VAL_MAX, 1'b1);
        push_element(VAL_MAX, 1'b0);
        push_element(VAL_MIN, 1'b1);
        push_element(5, 1'b0);
        push_element(5, 1'b1);
        push_element(1, 1'b0);
        push_element(0, 1'b0);
        push_element(-1, 1'b1);
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_pct = (p < 4) ? 30 : (p < 8) ? 69 : 0;
            write_swap_mask(phase_mask(p));
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target)
                queue_array(pick_length());
            wait_drained();
        end

        repeat (80) @(posedge clk);
        $display("Checked %0d arrays from %0d element transactions under %0d swap masks.",
                 arrays_checked, items_queued, masks_written);
        $display("Verdicts: %0d sortable, %0d not sortable, %0d with dropped elements.",
                 sortable_count, arrays_checked - sortable_count, overflow_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
